### hw/rtl/tmis_pkg.sv
// Shared constants, codes and types of the tape machine instruction step unit.
package tmis_pkg;

  // Tape size and the derived cell address width.
  localparam int unsigned TAPE_CELLS = 32768;
  localparam int unsigned TAPE_AW    = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;

  // Loop stack depth, the count width (holds the depth itself) and the entry address width.
  localparam int unsigned LOOP_STACK_DEPTH = 64;
  localparam int unsigned STACK_CW = $clog2(LOOP_STACK_DEPTH + 1);
  localparam int unsigned STACK_AW = (LOOP_STACK_DEPTH > 1) ? $clog2(LOOP_STACK_DEPTH) : 1;

  // Field widths.
  localparam int unsigned CELL_W = 8;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned NEST_W = 7;

  // Skip nesting saturates here.
  localparam logic [NEST_W-1:0] SKIP_NEST_MAX = 7'd127;

  // Program characters that act.
  localparam logic [7:0] OP_RIGHT = 8'h3E;  // '>'
  localparam logic [7:0] OP_LEFT  = 8'h3C;  // '<'
  localparam logic [7:0] OP_INC   = 8'h2B;  // '+'
  localparam logic [7:0] OP_DEC   = 8'h2D;  // '-'
  localparam logic [7:0] OP_IN    = 8'h2C;  // ','
  localparam logic [7:0] OP_OUT   = 8'h2E;  // '.'
  localparam logic [7:0] OP_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] OP_CLOSE = 8'h5D;  // ']'

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNMATCHED = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  // Tape write request from the execute stage.
  typedef struct packed {
    logic               en;
    logic [TAPE_AW-1:0] addr;
    logic [CELL_W-1:0]  data;
  } tape_wr_t;

  // Loop stack push request from the execute stage.
  typedef struct packed {
    logic                en;
    logic [STACK_AW-1:0] addr;
    logic [POS_W-1:0]    data;
  } stack_wr_t;

endpackage

### hw/rtl/tmis_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tmis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; data holds between reads.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/tmis_tape.sv
// Tape memory with the clearing sweep after reset and write-to-read forwarding.
module tmis_tape (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,
  input  logic [tmis_pkg::TAPE_AW-1:0]         rd_addr_i,
  input  tmis_pkg::tape_wr_t                   wr_i,
  output logic [tmis_pkg::CELL_W-1:0]          cell_o,
  output logic                                 busy_o
);
  import tmis_pkg::*;

  localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_CELLS - 1);

  logic               clr_busy_q, clr_busy_d;
  logic [TAPE_AW-1:0] clr_addr_q, clr_addr_d;
  logic               fwd_vld_q;
  logic [TAPE_AW-1:0] fwd_addr_q;
  logic [CELL_W-1:0]  fwd_data_q;
  logic [TAPE_AW-1:0] rd_addr_q;
  logic               ram_we;
  logic [TAPE_AW-1:0] ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [CELL_W-1:0]  ram_rdata;

  // Clearing sweep: one cell per cycle from address zero up to the last cell.
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == TAPE_LAST) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // The sweep owns the write port until it is done.
  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = wr_i.en;
      ram_waddr = wr_i.addr;
      ram_wdata = wr_i.data;
    end
  end

  tmis_ram #(
    .WIDTH (CELL_W),
    .DEPTH (TAPE_CELLS),
    .AW    (TAPE_AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (rd_en_i),
    .rd_addr_i (rd_addr_i),
    .rd_data_o (ram_rdata)
  );

  // The most recent item write is kept, since a read issued at the same edge misses it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (wr_i.en && !clr_busy_q) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && !clr_busy_q) begin
      fwd_addr_q <= wr_i.addr;
      fwd_data_q <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_addr_q <= rd_addr_i;
    end
  end

  // The latest write to the read cell wins over the memory data.
  assign cell_o = (fwd_vld_q && (fwd_addr_q == rd_addr_q)) ? fwd_data_q : ram_rdata;
  assign busy_o = clr_busy_q;

endmodule

### hw/rtl/tmis_stack.sv
// Loop position stack memory with write-to-read forwarding of the last push.
module tmis_stack (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [tmis_pkg::STACK_AW-1:0] rd_addr_i,
  input  tmis_pkg::stack_wr_t           wr_i,
  output logic [tmis_pkg::POS_W-1:0]    top_o
);
  import tmis_pkg::*;

  logic                fwd_vld_q;
  logic [STACK_AW-1:0] fwd_addr_q;
  logic [POS_W-1:0]    fwd_data_q;
  logic [STACK_AW-1:0] rd_addr_q;
  logic [POS_W-1:0]    ram_rdata;

  tmis_ram #(
    .WIDTH (POS_W),
    .DEPTH (LOOP_STACK_DEPTH),
    .AW    (STACK_AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_i.en),
    .wr_addr_i (wr_i.addr),
    .wr_data_i (wr_i.data),
    .rd_en_i   (rd_en_i),
    .rd_addr_i (rd_addr_i),
    .rd_data_o (ram_rdata)
  );

  // Track the latest push for a pop read issued at the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (wr_i.en) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      fwd_addr_q <= wr_i.addr;
      fwd_data_q <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_addr_q <= rd_addr_i;
    end
  end

  assign top_o = (fwd_vld_q && (fwd_addr_q == rd_addr_q)) ? fwd_data_q : ram_rdata;

endmodule

### hw/rtl/tape_machine_instruction_step_unit.sv
// Top level of the tape machine instruction step unit: execute stage and result register.
//
//  Channel   | Dir | Signals                        | Contents
//  ----------+-----+--------------------------------+------------------------------------------
//  s_axis    | in  | tvalid, tready, tdata[31:0]    | opcode, position, input_byte
//  m_axis    | out | tvalid, tready, tdata[31:0]    | out_valid, out_byte, jump, jump_target,
//            |     |                                | status
//
// One instruction per cycle unless the execute stage stalls or the tape sweep runs. The tape
// cell and the stack top are read from their memories at the transfer edge and used in the
// execute stage, which writes back at its end; the last write to each memory is forwarded
// to a read issued at the same edge. After reset the tape is swept to zero, one cell per
// cycle over all TAPE_CELLS cells (32768 by default); s_axis_tready stays low until the sweep ends.
// A result waits in the output register while the next instruction is taken in; the execute
// stage stalls only when that register is full and not being drained.
module tape_machine_instruction_step_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [7:0] opcode, [23:8] position, [31:24] input_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [0] out_valid, [8:1] out_byte, [9] jump,
                                      // [25:10] jump_target, [27:26] status, [31:28] zero
);
  import tmis_pkg::*;

  localparam logic [TAPE_AW-1:0]  TAPE_LAST  = TAPE_AW'(TAPE_CELLS - 1);
  localparam logic [STACK_CW-1:0] STACK_FULL = STACK_CW'(LOOP_STACK_DEPTH);

  // Handshake.
  logic accept, ex_fire, out_free, tape_busy;

  // Execute stage.
  logic              ex_valid_q;
  logic [7:0]        ex_op_q;
  logic [POS_W-1:0]  ex_pos_q;
  logic [CELL_W-1:0] ex_in_q;

  // Architectural state.
  logic [TAPE_AW-1:0]  dp_q, dp_d, dp_n;
  logic [STACK_CW-1:0] count_q, count_d, count_n;
  logic                skip_q, skip_d, skip_n;
  logic [NEST_W-1:0]   nest_q, nest_d, nest_n;

  // Memory ports.
  logic [CELL_W-1:0]   cur_cell;
  logic [POS_W-1:0]    top;
  logic [STACK_CW-1:0] pop_idx;
  tape_wr_t            tape_wr;
  stack_wr_t           stack_wr;

  // Result of the execute stage.
  logic              r_ovalid, r_jump;
  logic [CELL_W-1:0] r_obyte;
  logic [POS_W-1:0]  r_target;
  status_e           r_status;

  // Output register.
  logic              m_valid_q;
  logic              m_ovalid_q, m_jump_q;
  logic [CELL_W-1:0] m_obyte_q;
  logic [POS_W-1:0]  m_target_q;
  status_e           m_status_q;

  // Flow control between input, execute stage and output register.
  assign out_free      = !m_valid_q || m_axis_tready;
  assign ex_fire       = ex_valid_q && out_free;
  assign s_axis_tready = !tape_busy && (!ex_valid_q || ex_fire);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Execute: next state, memory writes and the result of the instruction in the stage.
  always_comb begin
    dp_n     = dp_q;
    count_n  = count_q;
    skip_n   = skip_q;
    nest_n   = nest_q;
    r_ovalid = 1'b0;
    r_obyte  = '0;
    r_jump   = 1'b0;
    r_target = '0;
    r_status = STATUS_OK;
    tape_wr.en    = 1'b0;
    tape_wr.addr  = dp_q;
    tape_wr.data  = cur_cell;
    stack_wr.en   = 1'b0;
    stack_wr.addr = count_q[STACK_AW-1:0];
    stack_wr.data = ex_pos_q;

    if (skip_q) begin
      // Skipping a loop body: only brackets count nesting.
      if (ex_op_q == OP_OPEN) begin
        if (nest_q >= SKIP_NEST_MAX) begin
          nest_n   = SKIP_NEST_MAX;
          r_status = STATUS_OVERFLOW;
        end else begin
          nest_n = nest_q + 1'b1;
        end
      end else if (ex_op_q == OP_CLOSE) begin
        if (nest_q == '0) begin
          skip_n = 1'b0;
        end else begin
          nest_n = nest_q - 1'b1;
        end
      end
    end else begin
      unique case (ex_op_q)
        OP_RIGHT: dp_n = (dp_q == TAPE_LAST) ? '0 : dp_q + 1'b1;
        OP_LEFT:  dp_n = (dp_q == '0) ? TAPE_LAST : dp_q - 1'b1;
        OP_INC: begin
          tape_wr.en   = 1'b1;
          tape_wr.data = cur_cell + 1'b1;
        end
        OP_DEC: begin
          tape_wr.en   = 1'b1;
          tape_wr.data = cur_cell - 1'b1;
        end
        OP_IN: begin
          tape_wr.en   = 1'b1;
          tape_wr.data = ex_in_q;
        end
        OP_OUT: begin
          r_ovalid = 1'b1;
          r_obyte  = cur_cell;
        end
        OP_OPEN: begin
          if (cur_cell == '0) begin
            skip_n = 1'b1;
            nest_n = '0;
          end else if (count_q >= STACK_FULL) begin
            r_status = STATUS_OVERFLOW;
          end else begin
            stack_wr.en = 1'b1;
            count_n     = count_q + 1'b1;
          end
        end
        OP_CLOSE: begin
          if (count_q == '0) begin
            r_status = STATUS_UNMATCHED;
          end else begin
            count_n = count_q - 1'b1;
            if (cur_cell != '0) begin
              r_jump   = 1'b1;
              r_target = top;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Commit only when the stage hands its result on.
    tape_wr.en  = tape_wr.en && ex_fire;
    stack_wr.en = stack_wr.en && ex_fire;
    dp_d    = ex_fire ? dp_n : dp_q;
    count_d = ex_fire ? count_n : count_q;
    skip_d  = ex_fire ? skip_n : skip_q;
    nest_d  = ex_fire ? nest_n : nest_q;
  end

  // The entering instruction reads at the state left by the one now finishing.
  assign pop_idx = count_d - 1'b1;

  tmis_tape u_tape (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (dp_d),
    .wr_i      (tape_wr),
    .cell_o    (cur_cell),
    .busy_o    (tape_busy)
  );

  tmis_stack u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (pop_idx[STACK_AW-1:0]),
    .wr_i      (stack_wr),
    .top_o     (top)
  );

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      dp_q       <= '0;
      count_q    <= '0;
      skip_q     <= 1'b0;
      nest_q     <= '0;
    end else begin
      if (accept) begin
        ex_valid_q <= 1'b1;
      end else if (ex_fire) begin
        ex_valid_q <= 1'b0;
      end
      if (out_free) begin
        m_valid_q <= ex_valid_q;
      end
      dp_q    <= dp_d;
      count_q <= count_d;
      skip_q  <= skip_d;
      nest_q  <= nest_d;
    end
  end

  // Payload registers of the execute stage and the output register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_op_q  <= s_axis_tdata[7:0];
      ex_pos_q <= s_axis_tdata[23:8];
      ex_in_q  <= s_axis_tdata[31:24];
    end
    if (ex_fire) begin
      m_ovalid_q <= r_ovalid;
      m_obyte_q  <= r_obyte;
      m_jump_q   <= r_jump;
      m_target_q <= r_target;
      m_status_q <= r_status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_status_q, m_target_q, m_jump_q, m_obyte_q, m_ovalid_q};

endmodule
